### sv/base85_group_decoder_defines.svh
// Assertion macros shared by the base-85 group decoder RTL.
// Included by name from the modules that carry assertions; no other dependencies.
`ifndef BASE85_GROUP_DECODER_DEFINES_SVH
`define BASE85_GROUP_DECODER_DEFINES_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define B85_ASSERT_ALWAYS(label, clk_sig, rst_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error("b85 assertion failed");

// Check a consequence in the cycle after its trigger.
`define B85_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("b85 assertion failed");

`else

`define B85_ASSERT_ALWAYS(label, clk_sig, rst_sig, prop)
`define B85_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

### sv/b85gd_pkg.sv
// Types, status codes and alphabet/weight functions for the base-85 group decoder.
// Self-contained; imported by base85_group_decoder.
`default_nettype none

package b85gd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] digit;
  } digit_t;

  // Map a character to its digit; ok is low outside the alphabet.
  function automatic digit_t decode_char(logic [7:0] c);
    digit_t d;
    logic [7:0] diff;
    d.ok    = 1'b1;
    d.digit = 7'd0;
    diff    = 8'd0;
    if (c == 8'h21) begin
      diff = 8'd0;
    end else if (c >= 8'h28 && c <= 8'h3E) begin
      diff = c - 8'h27;
    end else if (c >= 8'h40 && c <= 8'h5B) begin
      diff = c - 8'h28;
    end else if (c >= 8'h5D && c <= 8'h5F) begin
      diff = c - 8'h29;
    end else if (c >= 8'h61 && c <= 8'h7E) begin
      diff = c - 8'h2A;
    end else begin
      d.ok = 1'b0;
    end
    d.digit = diff[6:0];
    return d;
  endfunction

  // Place value of the digit at a given position, least significant first.
  function automatic logic [25:0] digit_weight(logic [2:0] pos);
    logic [25:0] w;
    case (pos)
      3'd0:    w = 26'd1;
      3'd1:    w = 26'd85;
      3'd2:    w = 26'd7225;
      3'd3:    w = 26'd614125;
      3'd4:    w = 26'd52200625;
      default: w = 26'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/base85_group_decoder.sv
// Base-85 group decoder: one character in per transaction, decoded bytes out.
// Depends on b85gd_pkg and base85_group_decoder_defines.svh.
`default_nettype none

`include "base85_group_decoder_defines.svh"

// The block takes one base-85 character per input transaction and returns
// the decoded bytes, least significant byte of each group first. Digits
// gather into a group of five; a full group gives four bytes, and the
// character marked end_of_data closes a partial group of n digits, giving
// one byte for n=1 and n-1 bytes otherwise. A character outside the
// alphabet, or a group whose value does not fit its byte count, gives a
// single result with out_byte 0 and a nonzero status, and clears the group.
// last_in_run marks the final result caused by one input character.
// Rate: the input side takes one character per clock while in_ready is
// high. The digit accumulate (one 26x7 multiply and a 33-bit add) and the
// group checks finish in the accepting cycle and land in a one-entry
// record register; a serializer then hands out one byte per clock while
// out_ready is high. The first result of a character passes through the
// record register and then the serializer register before it is offered.
// in_ready is low only while the record register holds a record waiting
// behind a group that the serializer is still draining. A steady run of
// full groups, five characters for four bytes, never stalls the input
// while out_ready stays high; an error or a short closing group that lands
// right behind a full group holds in_ready low until that group has drained.
module base85_group_decoder
  import b85gd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] code_char,
  input  wire logic       end_of_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic            last_in_run
);

  // Group accumulator.
  logic [32:0] group_value;
  logic [32:0] group_value_next;
  logic [2:0]  digit_count;
  logic [2:0]  digit_count_next;

  // Record register: one decoded group (or error) waiting for the serializer.
  logic        rec_valid;
  logic [31:0] rec_value;
  logic [1:0]  rec_left;      // bytes in the record minus one
  status_t     rec_status;

  // Serializer: byte currently offered on the output.
  logic        ser_valid;
  logic [31:0] ser_value;
  logic [1:0]  ser_left;      // bytes still to send after this one
  status_t     ser_status;

  // Record produced by the transaction accepted this cycle.
  logic        new_valid;
  logic [31:0] new_value;
  logic [1:0]  new_left;
  status_t     new_status;

  logic        in_fire;
  logic        out_fire;
  logic        load_ser;
  digit_t      dec;
  logic [32:0] prod;
  logic [32:0] sum;
  logic [2:0]  cnt_inc;

  assign out_fire = out_valid && out_ready;
  // Serializer takes the next record when empty or on handing out its last byte.
  assign load_ser = !ser_valid || (out_fire && (ser_left == 2'd0));
  assign in_ready = !rec_valid || load_ser;
  assign in_fire  = in_valid && in_ready;

  assign dec     = decode_char(code_char);
  assign prod    = {7'd0, digit_weight(digit_count)} * {26'd0, dec.digit};
  assign sum     = group_value + prod;
  assign cnt_inc = digit_count + 3'd1;

  // Next group state and the record for the accepted character.
  always_comb begin
    group_value_next = group_value;
    digit_count_next = digit_count;
    new_valid        = 1'b0;
    new_value        = 32'd0;
    new_left         = 2'd0;
    new_status       = STATUS_OK;
    if (in_fire) begin
      if (!dec.ok) begin
        // Drop the group and report one bad character.
        group_value_next = 33'd0;
        digit_count_next = 3'd0;
        new_valid        = 1'b1;
        new_status       = STATUS_BAD_CHAR;
      end else if (cnt_inc == 3'd5) begin
        group_value_next = 33'd0;
        digit_count_next = 3'd0;
        new_valid        = 1'b1;
        if (sum[32]) begin
          new_status = STATUS_OVERFLOW;
        end else begin
          new_value = sum[31:0];
          new_left  = 2'd3;
        end
      end else if (end_of_data) begin
        // Close a partial group: missing digits count as zero.
        group_value_next = 33'd0;
        digit_count_next = 3'd0;
        new_valid        = 1'b1;
        case (cnt_inc)
          3'd4: begin
            new_left = 2'd2;
            if (sum[31:24] != 8'd0) new_status = STATUS_OVERFLOW;
          end
          3'd3: begin
            new_left = 2'd1;
            if (sum[31:16] != 16'd0) new_status = STATUS_OVERFLOW;
          end
          default: begin
            new_left = 2'd0;
            if (sum[31:8] != 24'd0) new_status = STATUS_OVERFLOW;
          end
        endcase
        if (new_status == STATUS_OK) begin
          new_value = sum[31:0];
        end else begin
          new_left = 2'd0;
        end
      end else begin
        // Mid-group character: advance the accumulator, no result.
        group_value_next = sum;
        digit_count_next = cnt_inc;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_value <= 33'd0;
      digit_count <= 3'd0;
      rec_valid   <= 1'b0;
      ser_valid   <= 1'b0;
    end else begin
      group_value <= group_value_next;
      digit_count <= digit_count_next;
      rec_valid   <= new_valid || (rec_valid && !load_ser);
      if (load_ser) begin
        ser_valid <= rec_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (new_valid) begin
      rec_value  <= new_value;
      rec_left   <= new_left;
      rec_status <= new_status;
    end
    if (load_ser) begin
      ser_value  <= rec_value;
      ser_left   <= rec_left;
      ser_status <= rec_status;
    end else if (out_fire) begin
      // Advance to the next byte of the group.
      ser_value <= {8'd0, ser_value[31:8]};
      ser_left  <= ser_left - 2'd1;
    end
  end

  assign out_valid   = ser_valid;
  assign out_byte    = ser_value[7:0];
  assign status      = ser_status;
  assign last_in_run = (ser_left == 2'd0);

  // An error record is always a single result.
  `B85_ASSERT_ALWAYS(a_err_single, clk, rst, !ser_valid || ser_status == STATUS_OK || ser_left == 2'd0)
  // The group never holds a completed fifth digit.
  `B85_ASSERT_ALWAYS(a_count_range, clk, rst, digit_count <= 3'd4)
  // A bad character clears the group.
  `B85_ASSERT_NEXT(a_bad_clears, clk, rst, in_fire && !dec.ok, digit_count == 3'd0)
  // A waiting record is never lost while the serializer is busy.
  `B85_ASSERT_NEXT(a_rec_held, clk, rst, rec_valid && !load_ser, rec_valid)
  // A group keeps the output busy until its last byte is taken.
  `B85_ASSERT_NEXT(a_run_continues, clk, rst, out_fire && !last_in_run, out_valid)

endmodule

`default_nettype wire

### test/tb_base85_group_decoder.sv
// Self-checking testbench for base85_group_decoder: directed and random character streams.
// Depends on b85gd_pkg (status codes) and the base85_group_decoder RTL; needs no other files.
`timescale 1ns / 100ps

module tb_base85_group_decoder
  import b85gd_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  // One decoded byte or one error, as the block should hand it out.
  typedef struct {
    logic [7:0] data;
    status_t    code;
    logic       last;
  } decoded_t;

  // Track the group being gathered, work out the bytes each accepted
  // character causes, and match them against what comes out of the block.
  class group_scoreboard;
    int          char_digit[256];
    logic [32:0] group_sum;
    int          group_len;
    decoded_t    expected_bytes[$];
    int          mismatches;
    int          chars_taken;
    int          results_seen;
    int          error_results;

    function new();
      int d;
      d = 0;
      for (int c = 0; c < 256; c++) begin
        char_digit[c] = -1;
        // Printable range minus the nine characters left out of the alphabet.
        if (c >= 8'h21 && c <= 8'h7E &&
            !(c inside {8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h3F, 8'h5C, 8'h60})) begin
          char_digit[c] = d;
          d++;
        end
      end
      group_sum     = '0;
      group_len     = 0;
      mismatches    = 0;
      chars_taken   = 0;
      results_seen  = 0;
      error_results = 0;
    endfunction

    function void push_result(logic [7:0] data, status_t code, logic last);
      decoded_t r;
      r.data = data;
      r.code = code;
      r.last = last;
      expected_bytes.push_back(r);
    endfunction

    function void push_bytes(logic [31:0] value, int count);
      for (int k = 0; k < count; k++)
        push_result(value[8*k +: 8], STATUS_OK, k == count - 1);
    endfunction

    function void take_char(logic [7:0] c, logic eod);
      int          d;
      logic [32:0] place;
      logic [32:0] full;
      int          nbytes;
      chars_taken++;
      d = char_digit[c];
      if (d < 0) begin
        group_sum = '0;
        group_len = 0;
        push_result(8'd0, STATUS_BAD_CHAR, 1'b1);
        return;
      end
      place = 33'd1;
      for (int k = 0; k < group_len; k++)
        place = place * 33'd85;
      group_sum = group_sum + place * 33'(d);
      group_len++;
      if (group_len == 5) begin
        full      = group_sum;
        group_sum = '0;
        group_len = 0;
        if (full > 33'hFFFF_FFFF)
          push_result(8'd0, STATUS_OVERFLOW, 1'b1);
        else
          push_bytes(full[31:0], 4);
      end else if (eod) begin
        // Missing digits count as zero; the group must fit its byte count.
        full      = group_sum;
        nbytes    = (group_len > 1) ? group_len - 1 : 1;
        group_sum = '0;
        group_len = 0;
        if ((full >> (8 * nbytes)) != 0)
          push_result(8'd0, STATUS_OVERFLOW, 1'b1);
        else
          push_bytes(full[31:0], nbytes);
      end
    endfunction

    function void match_result(logic [7:0] data, logic [1:0] code, logic last);
      decoded_t want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result byte=%h status=%0d last=%b", $realtime,
                 data, code, last);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (want.code != STATUS_OK)
        error_results++;
      if (data !== want.data) begin
        $display("%0t: out_byte expected %h actual %h", $realtime, want.data, data);
        mismatches++;
      end
      if (code !== want.code) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: last_in_run expected %b actual %b", $realtime, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] code_char   = 8'd0;
  logic       end_of_data = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last_in_run;

  group_scoreboard sb;
  logic [7:0]      alphabet[85];
  int              in_idle_pct  = 0;
  int              out_idle_pct = 0;
  int              cycle_count  = 0;

  base85_group_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .code_char   (code_char),
    .end_of_data (end_of_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .status      (status),
    .last_in_run (last_in_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Sample both channels at the edge; values are the ones settled before it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.take_char(code_char, end_of_data);
      if (out_valid && out_ready)
        sb.match_result(out_byte, status, last_in_run);
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               sb.expected_bytes.size());
      $display("status: fail");
      $finish;
    end
  end

  // Offer one character and hold it until the block takes the transaction.
  // A gap, if drawn, drops valid for whole cycles before the offer.
  task automatic send_char(input logic [7:0] c, input logic eod);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    code_char   <= c;
    end_of_data <= eod;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // Spell a value as ndig digits, least significant first; mark the last one
  // as end of data when eod is set.
  task automatic send_group(input logic [32:0] value, input int ndig, input logic eod);
    logic [32:0] rest;
    rest = value;
    for (int k = 0; k < ndig; k++) begin
      send_char(alphabet[rest % 85], eod && (k == ndig - 1));
      rest = rest / 85;
    end
  endtask

  // Pick a group value for ndig digits: one that fits its byte count, or one past
  // it that ndig digits can spell when too_big is set. Now and then take the exact edge.
  function automatic logic [32:0] pick_value(input int ndig, input logic too_big);
    longint span;
    longint fit_lim;
    span = 1;
    for (int k = 0; k < ndig; k++)
      span = span * 85;
    if (ndig == 5)
      fit_lim = 64'h1_0000_0000;
    else if (ndig == 1)
      fit_lim = span;
    else
      fit_lim = 64'd1 << (8 * (ndig - 1));
    if (too_big && fit_lim < span) begin
      if ($urandom_range(0, 7) == 0)
        return 33'(fit_lim);
      return 33'(fit_lim + $urandom_range(0, 32'(span - 1 - fit_lim)));
    end
    case ($urandom_range(0, 7))
      0:       return 33'd0;
      1:       return 33'(fit_lim - 1);
      default: return 33'(longint'($urandom) % fit_lim);
    endcase
  endfunction

  // Random stream: mostly well-formed groups with random content, the rest
  // raw noise, groups cut short by a bad character, and random digit runs.
  task automatic run_random(input int count);
    int       sent;
    int       pick;
    int       ndig;
    logic     eod;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      ndig = $urandom_range(1, 5);
      if (pick < 8) begin
        send_char(8'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 16) begin
        // Cut a group short with a character outside the alphabet.
        ndig = $urandom_range(1, 4);
        send_group(pick_value(ndig, 1'b0), ndig, 1'b0);
        send_char(($urandom_range(0, 1) != 0) ? 8'h60 : 8'($urandom_range(8'h7F, 8'hFF)),
                  1'($urandom));
        sent += ndig + 1;
      end else if (pick < 28) begin
        for (int k = 0; k < ndig; k++)
          send_char(alphabet[$urandom_range(0, 84)], (k == ndig - 1) && (ndig < 5));
        sent += ndig;
      end else begin
        // Full groups take end of data at random; a partial group needs it.
        eod = (ndig < 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
        send_group(pick_value(ndig, $urandom_range(0, 9) == 0), ndig, eod);
        sent += ndig;
      end
    end
  endtask

  initial begin
    sb = new();
    for (int c = 0; c < 256; c++)
      if (sb.char_digit[c] >= 0)
        alphabet[sb.char_digit[c]] = 8'(c);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles lightly, receiver stalls often.
    in_idle_pct  = 20;
    out_idle_pct = 56;

    // Single digit closed by end of data, lowest and highest digit.
    send_char(8'h21, 1'b1);
    send_char(8'h7E, 1'b1);
    // Two digits that do not fit one byte.
    send_group(33'd256, 2, 1'b1);
    // Three digits at the top of two bytes, four digits just over three.
    send_group(33'h0_0000_FFFF, 3, 1'b1);
    send_group(33'h0_0100_0000, 4, 1'b1);
    // Full group at the 32-bit maximum with end of data on its fifth digit.
    send_group(33'h0_FFFF_FFFF, 5, 1'b1);
    // Full group one past the maximum.
    send_group(33'h1_0000_0000, 5, 1'b0);
    // Bad characters: code 0xFF mid-group with end of data, then codes 0x00 and 0x22.
    send_char(8'h28, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'h22, 1'b0);

    run_random(65);

    // Phase two: swap the pacing.
    in_idle_pct  = 56;
    out_idle_pct = 20;
    run_random(65);

    // Phase three: full rate on both sides.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random(65);
    in_valid <= 1'b0;

    // Drain the results still due, then keep clocking to catch any stray result.
    while (sb.expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decoded %0d characters into %0d results (%0d of them errors)",
             sb.chars_taken, sb.results_seen, sb.error_results);
    $display("pacing: light/heavy, heavy/light and no stalls; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/b85gd_pkg.sv
sv/base85_group_decoder.sv
test/tb_base85_group_decoder.sv
